// ===== rtl/fpbm_pkg.sv =====
`default_nettype none
package fpbm_pkg;

  localparam int unsigned Blocks      = 256;
  localparam int unsigned Pages       = 256;
  localparam int unsigned Streams     = 4;
  localparam int unsigned Kinds       = 3;
  localparam int unsigned Slots       = Kinds * Streams;
  localparam int unsigned BlkW        = $clog2(Blocks);
  localparam int unsigned PageW       = $clog2(Pages);
  localparam int unsigned WordSelW    = PageW - 6;
  localparam int unsigned BmDepth     = Blocks * (Pages / 64);
  localparam int unsigned BmAddrW     = $clog2(BmDepth);
  localparam int unsigned SlotW       = $clog2(Slots);
  localparam int unsigned WpW         = PageW + 1;
  localparam int unsigned FreeW       = 17;
  localparam int unsigned CountW      = BlkW + 1;

  localparam logic [FreeW-1:0]  TotalPages = FreeW'(Blocks * Pages);
  localparam logic [WpW-1:0]    PagesFull  = WpW'(Pages);
  localparam logic [7:0]        NoOwner    = 8'hff;
  localparam logic [CountW-1:0] PoolAtReset = CountW'(Blocks - Slots);
  localparam logic [15:0]       SeqAtReset  = 16'(Blocks);

  typedef enum logic [3:0] {
    OP_USER_ALLOC  = 4'd0,
    OP_GC_ALLOC    = 4'd1,
    OP_XLAT_ALLOC  = 4'd2,
    OP_INVALIDATE  = 4'd3,
    OP_ERASE       = 4'd4,
    OP_READ_START  = 4'd5,
    OP_READ_DONE   = 4'd6,
    OP_PROG_START  = 4'd7,
    OP_PROG_DONE   = 4'd8,
    OP_GC_START    = 4'd9,
    OP_GC_DONE     = 4'd10,
    OP_BLOCK_QUERY = 4'd11,
    OP_WEAR_QUERY  = 4'd12,
    OP_UNUSED_13   = 4'd13,
    OP_UNUSED_14   = 4'd14,
    OP_UNUSED_15   = 4'd15
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_POOL_EMPTY = 2'd1,
    ST_NOT_OWNER = 2'd2,
    ST_NO_PAGES  = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_MOD,
    S_SCAN,
    S_SCAN_END,
    S_INST,
    S_WIPE,
    S_DONE
  } state_e;

  // per-block record
  typedef struct packed {
    logic [WpW-1:0] wp;
    logic [WpW-1:0] inv_cnt;
    logic [15:0]    erase_cnt;
    logic [7:0]     owner;
    logic           gc_mark;
    logic [7:0]     reads;
    logic [7:0]     progs;
    logic           in_pool;
    logic [15:0]    key;
    logic [15:0]    seq;
  } entry_t;

  // result item, last field first so status lands in the low bits
  typedef struct packed {
    logic [15:0]       erase_spread;
    logic [BlkW-1:0]   coldest_block;
    logic              program_ongoing;
    logic              gc_ongoing;
    logic              can_collect;
    logic              page_valid;
    logic [CountW-1:0] free_block_count;
    logic              new_block_opened;
    logic [PageW-1:0]  alloc_page;
    logic [BlkW-1:0]   alloc_block;
    status_e           status;
  } res_t;

endpackage
`default_nettype wire

// ===== rtl/flash_plane_block_manager_top.sv =====
`default_nettype none
// the wear query scans all 256 block entries, as does an allocation that has to open
//   a new block (each pool pick scans 256 entries)
// throughput: one item at a time; the block memory scan reads one entry per cycle
// reset: asynchronous, active low; a clearing pass over the 1024 bitmap words then
//   initialises the page bitmap and block records, during which no item is accepted
module flash_plane_block_manager_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // op[3:0], stream[5:4], block_index[13:6], page_index[21:14], mapping_data[22]
  input  wire logic [23:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // status[1:0], alloc_block[9:2], alloc_page[17:10], new_block_opened[18],
  // free_block_count[27:19], page_valid[28], can_collect[29], gc_ongoing[30],
  // program_ongoing[31], coldest_block[39:32], erase_spread[55:40]
  output logic [55:0]      m_axis_tdata,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_data_i
);

  localparam int unsigned BW = fpbm_pkg::BlkW;
  localparam int unsigned PW = fpbm_pkg::PageW;

  // memories
  fpbm_pkg::entry_t blk_mem [fpbm_pkg::Blocks];
  logic [63:0]      bm_mem  [fpbm_pkg::BmDepth];

  fpbm_pkg::entry_t brd_q;
  logic [63:0]      bmrd_q;
  logic [BW-1:0]    braddr;
  logic             bwe;
  logic [BW-1:0]    bwaddr;
  fpbm_pkg::entry_t bwdata;
  logic             mwe;
  logic [fpbm_pkg::BmAddrW-1:0] mwaddr;
  logic [63:0]      mwdata;

  // control and datapath registers
  fpbm_pkg::state_e state_q, state_d;
  logic [fpbm_pkg::BmAddrW-1:0] clr_q, clr_d;
  fpbm_pkg::op_e    op_q, op_d;
  logic [1:0]       stream_q, stream_d;
  logic [BW-1:0]    blk_q, blk_d;
  logic [PW-1:0]    page_q, page_d;
  logic [BW-1:0]    cur_q, cur_d;
  logic             phase_q, phase_d;
  logic             inst_q, inst_d;
  logic [BW:0]      scan_q, scan_d;
  logic             found_q, found_d;
  logic [BW-1:0]    best_q, best_d;
  fpbm_pkg::entry_t bent_q, bent_d;
  logic [15:0]      mn_q, mn_d, mx_q, mx_d;
  logic [BW-1:0]    cold_q, cold_d;
  logic [fpbm_pkg::WordSelW-1:0] wipe_q, wipe_d;
  logic [fpbm_pkg::FreeW-1:0]    free_q, free_d;
  logic [fpbm_pkg::CountW-1:0]   pool_q, pool_d;
  logic [15:0]      nseq_q, nseq_d;
  logic             dwl_q;
  logic [BW-1:0]    otbl_q [fpbm_pkg::Slots];
  logic             otbl_we;
  fpbm_pkg::res_t   res_q, res_d;
  logic             ovalid_q, ovalid_d;

  logic             accept;
  logic [1:0]       in_kind;
  logic [fpbm_pkg::SlotW-1:0] slot;
  logic             is_alloc;

  assign accept        = s_axis_tvalid & s_axis_tready;
  assign s_axis_tready = (state_q == fpbm_pkg::S_IDLE) & ~ovalid_q;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = res_q;
  assign cfg_ready_o   = 1'b1;

  // slot of the open block for this stream and write kind
  assign in_kind  = op_q[1:0];
  assign slot     = fpbm_pkg::SlotW'({stream_q, 1'b0}) + fpbm_pkg::SlotW'(stream_q)
                    + fpbm_pkg::SlotW'(in_kind);
  assign is_alloc = (op_q == fpbm_pkg::OP_USER_ALLOC) || (op_q == fpbm_pkg::OP_GC_ALLOC)
                    || (op_q == fpbm_pkg::OP_XLAT_ALLOC);

  // the scan walks the block memory, otherwise the target block is read
  assign braddr = (state_q == fpbm_pkg::S_SCAN) ? scan_q[BW-1:0] : cur_q;

  always_ff @(posedge clk_i) begin
    brd_q  <= blk_mem[braddr];
    bmrd_q <= bm_mem[{blk_q, page_q[PW-1:6]}];
    if (bwe) begin
      blk_mem[bwaddr] <= bwdata;
    end
    if (mwe) begin
      bm_mem[mwaddr] <= mwdata;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      fpbm_pkg::S_CLEAR: begin
        if (clr_q == fpbm_pkg::BmAddrW'(fpbm_pkg::BmDepth - 1)) begin
          state_d = fpbm_pkg::S_IDLE;
        end
      end
      fpbm_pkg::S_IDLE: begin
        if (accept) begin
          case (fpbm_pkg::op_e'(s_axis_tdata[3:0]))
            fpbm_pkg::OP_USER_ALLOC, fpbm_pkg::OP_GC_ALLOC, fpbm_pkg::OP_XLAT_ALLOC: begin
              state_d = (free_q == '0) ? fpbm_pkg::S_DONE : fpbm_pkg::S_READ;
            end
            fpbm_pkg::OP_WEAR_QUERY: state_d = fpbm_pkg::S_SCAN;
            fpbm_pkg::OP_UNUSED_13, fpbm_pkg::OP_UNUSED_14,
            fpbm_pkg::OP_UNUSED_15: state_d = fpbm_pkg::S_DONE;
            default: state_d = fpbm_pkg::S_READ;
          endcase
        end
      end
      fpbm_pkg::S_READ: state_d = fpbm_pkg::S_MOD;
      fpbm_pkg::S_MOD: begin
        if (is_alloc) begin
          if (!inst_q && brd_q.wp >= fpbm_pkg::PagesFull) begin
            state_d = fpbm_pkg::S_SCAN;
          end else if (brd_q.wp + 1'b1 >= fpbm_pkg::PagesFull) begin
            state_d = fpbm_pkg::S_SCAN;
          end else begin
            state_d = fpbm_pkg::S_DONE;
          end
        end else if (op_q == fpbm_pkg::OP_ERASE) begin
          state_d = fpbm_pkg::S_WIPE;
        end else begin
          state_d = fpbm_pkg::S_DONE;
        end
      end
      fpbm_pkg::S_SCAN: begin
        if (scan_q[BW]) begin
          state_d = fpbm_pkg::S_SCAN_END;
        end
      end
      fpbm_pkg::S_SCAN_END: begin
        state_d = (op_q != fpbm_pkg::OP_WEAR_QUERY && found_q) ? fpbm_pkg::S_INST
                                                               : fpbm_pkg::S_DONE;
      end
      fpbm_pkg::S_INST: state_d = phase_q ? fpbm_pkg::S_DONE : fpbm_pkg::S_READ;
      fpbm_pkg::S_WIPE: begin
        if (wipe_q == '1) begin
          state_d = fpbm_pkg::S_DONE;
        end
      end
      fpbm_pkg::S_DONE: state_d = fpbm_pkg::S_IDLE;
      default: state_d = fpbm_pkg::S_IDLE;
    endcase
  end

  // datapath and memory writes
  always_comb begin
    fpbm_pkg::entry_t e;
    fpbm_pkg::entry_t ce;
    logic [WpW_L-1:0] wp_inc;
    logic [fpbm_pkg::FreeW-1:0] free_dec;
    logic [fpbm_pkg::WpW-1:0] gain;
    logic [fpbm_pkg::FreeW:0] fsum;
    logic [15:0] ec_new;
    logic better;
    logic [BW-1:0] sidx;
    logic [2:0] own;

    e        = brd_q;
    ce       = brd_q;
    wp_inc   = brd_q.wp + 1'b1;
    free_dec = free_q - 1'b1;
    gain     = (brd_q.inv_cnt < fpbm_pkg::PagesFull) ? fpbm_pkg::PagesFull - brd_q.inv_cnt : '0;
    fsum     = {1'b0, free_q} + (fpbm_pkg::FreeW + 1)'(gain);
    ec_new   = (brd_q.erase_cnt == 16'hffff) ? brd_q.erase_cnt : brd_q.erase_cnt + 1'b1;
    sidx     = scan_q[BW-1:0] - 1'b1;
    better   = !found_q || (brd_q.key < bent_q.key) ||
               (brd_q.key == bent_q.key && brd_q.seq < bent_q.seq);
    own      = 3'd0;

    clr_d    = clr_q;
    op_d     = op_q;
    stream_d = stream_q;
    blk_d    = blk_q;
    page_d   = page_q;
    cur_d    = cur_q;
    phase_d  = phase_q;
    inst_d   = inst_q;
    scan_d   = '0;
    found_d  = found_q;
    best_d   = best_q;
    bent_d   = bent_q;
    mn_d     = mn_q;
    mx_d     = mx_q;
    cold_d   = cold_q;
    wipe_d   = wipe_q;
    free_d   = free_q;
    pool_d   = pool_q;
    nseq_d   = nseq_q;
    res_d    = res_q;
    ovalid_d = ovalid_q & ~m_axis_tready;
    otbl_we  = 1'b0;
    bwe      = 1'b0;
    bwaddr   = cur_q;
    bwdata   = e;
    mwe      = 1'b0;
    mwaddr   = {blk_q, page_q[PW-1:6]};
    mwdata   = bmrd_q;

    case (state_q)
      fpbm_pkg::S_CLEAR: begin
        clr_d  = clr_q + 1'b1;
        mwe    = 1'b1;
        mwaddr = clr_q;
        mwdata = '0;
        if (clr_q < fpbm_pkg::BmAddrW'(fpbm_pkg::Blocks)) begin
          // blocks 0..11 are the open blocks, three per stream
          if (clr_q >= fpbm_pkg::BmAddrW'(9)) begin
            own = 3'd3;
          end else if (clr_q >= fpbm_pkg::BmAddrW'(6)) begin
            own = 3'd2;
          end else if (clr_q >= fpbm_pkg::BmAddrW'(3)) begin
            own = 3'd1;
          end
          bwe            = 1'b1;
          bwaddr         = clr_q[BW-1:0];
          bwdata         = '0;
          bwdata.seq     = 16'(clr_q);
          if (clr_q < fpbm_pkg::BmAddrW'(fpbm_pkg::Slots)) begin
            bwdata.owner = 8'(own);
          end else begin
            bwdata.owner   = fpbm_pkg::NoOwner;
            bwdata.in_pool = 1'b1;
          end
        end
      end
      fpbm_pkg::S_IDLE: begin
        if (accept) begin
          op_d     = fpbm_pkg::op_e'(s_axis_tdata[3:0]);
          stream_d = s_axis_tdata[5:4];
          blk_d    = s_axis_tdata[13:6];
          page_d   = s_axis_tdata[21:14];
          phase_d  = 1'b0;
          inst_d   = 1'b0;
          found_d  = 1'b0;
          wipe_d   = '0;
          res_d    = '0;
          cur_d    = s_axis_tdata[13:6];
          if (s_axis_tdata[3:0] <= 4'(fpbm_pkg::OP_XLAT_ALLOC)) begin
            cur_d = otbl_q[fpbm_pkg::SlotW'({s_axis_tdata[5:4], 1'b0})
                           + fpbm_pkg::SlotW'(s_axis_tdata[5:4])
                           + fpbm_pkg::SlotW'(s_axis_tdata[1:0])];
            if (free_q == '0) begin
              res_d.status = fpbm_pkg::ST_NO_PAGES;
            end
          end
        end
      end
      fpbm_pkg::S_MOD: begin
        found_d = 1'b0;
        case (op_q)
          fpbm_pkg::OP_USER_ALLOC, fpbm_pkg::OP_GC_ALLOC, fpbm_pkg::OP_XLAT_ALLOC: begin
            if (inst_q || brd_q.wp < fpbm_pkg::PagesFull) begin
              e.wp = wp_inc;
              if (op_q == fpbm_pkg::OP_USER_ALLOC && brd_q.progs != 8'hff) begin
                e.progs = brd_q.progs + 1'b1;
              end
              bwe               = 1'b1;
              free_d            = free_dec;
              res_d.alloc_block = cur_q;
              res_d.alloc_page  = brd_q.wp[PW-1:0];
              phase_d           = 1'b1;
              if (wp_inc < fpbm_pkg::PagesFull && free_dec == '0) begin
                res_d.status = fpbm_pkg::ST_NO_PAGES;
              end
            end
          end
          fpbm_pkg::OP_INVALIDATE: begin
            if (brd_q.owner != 8'(stream_q)) begin
              res_d.status = fpbm_pkg::ST_NOT_OWNER;
            end else if (!bmrd_q[page_q[5:0]]) begin
              mwe             = 1'b1;
              mwdata          = bmrd_q | (64'd1 << page_q[5:0]);
              e.inv_cnt       = brd_q.inv_cnt + 1'b1;
              bwe             = 1'b1;
            end
          end
          fpbm_pkg::OP_ERASE: begin
            free_d    = (fsum > {1'b0, fpbm_pkg::TotalPages}) ? fpbm_pkg::TotalPages
                                                              : fsum[fpbm_pkg::FreeW-1:0];
            e.wp        = '0;
            e.inv_cnt   = '0;
            e.erase_cnt = ec_new;
            e.owner     = fpbm_pkg::NoOwner;
            e.in_pool   = 1'b1;
            e.key       = dwl_q ? ec_new : 16'd0;
            e.seq       = nseq_q;
            bwe         = 1'b1;
            nseq_d      = nseq_q + 1'b1;
            if (!brd_q.in_pool) begin
              pool_d = pool_q + 1'b1;
            end
            if (free_d == '0) begin
              res_d.status = fpbm_pkg::ST_NO_PAGES;
            end
          end
          fpbm_pkg::OP_READ_START: begin
            if (brd_q.reads != 8'hff) e.reads = brd_q.reads + 1'b1;
            bwe = 1'b1;
          end
          fpbm_pkg::OP_READ_DONE: begin
            if (brd_q.reads != 8'd0) e.reads = brd_q.reads - 1'b1;
            bwe = 1'b1;
          end
          fpbm_pkg::OP_PROG_START: begin
            if (brd_q.progs != 8'hff) e.progs = brd_q.progs + 1'b1;
            bwe = 1'b1;
          end
          fpbm_pkg::OP_PROG_DONE: begin
            if (brd_q.progs != 8'd0) e.progs = brd_q.progs - 1'b1;
            bwe = 1'b1;
          end
          fpbm_pkg::OP_GC_START: begin
            e.gc_mark = 1'b1;
            bwe       = 1'b1;
          end
          fpbm_pkg::OP_GC_DONE: begin
            e.gc_mark = 1'b0;
            bwe       = 1'b1;
          end
          fpbm_pkg::OP_BLOCK_QUERY: begin
            res_d.page_valid      = ~bmrd_q[page_q[5:0]];
            res_d.can_collect     = (brd_q.reads == 8'd0) && (brd_q.progs == 8'd0);
            res_d.gc_ongoing      = brd_q.gc_mark;
            res_d.program_ongoing = brd_q.progs != 8'd0;
          end
          default: ;
        endcase
        bwdata = e;
      end
      fpbm_pkg::S_SCAN: begin
        scan_d = scan_q + 1'b1;
        if (scan_q != '0) begin
          if (op_q == fpbm_pkg::OP_WEAR_QUERY) begin
            if (sidx == '0) begin
              mn_d   = brd_q.erase_cnt;
              mx_d   = brd_q.erase_cnt;
              cold_d = '0;
            end else begin
              if (brd_q.erase_cnt < mn_q) begin
                mn_d   = brd_q.erase_cnt;
                cold_d = sidx;
              end
              if (brd_q.erase_cnt > mx_q) begin
                mx_d = brd_q.erase_cnt;
              end
            end
          end else if (brd_q.in_pool && better) begin
            found_d = 1'b1;
            best_d  = sidx;
            bent_d  = brd_q;
          end
        end
      end
      fpbm_pkg::S_SCAN_END: begin
        if (op_q == fpbm_pkg::OP_WEAR_QUERY) begin
          res_d.coldest_block = cold_q;
          res_d.erase_spread  = mx_q - mn_q;
        end else if (!found_q) begin
          res_d.status = fpbm_pkg::ST_POOL_EMPTY;
        end
      end
      fpbm_pkg::S_INST: begin
        ce         = bent_q;
        ce.in_pool = 1'b0;
        ce.owner   = 8'(stream_q);
        bwe        = 1'b1;
        bwaddr     = best_q;
        bwdata     = ce;
        otbl_we    = 1'b1;
        found_d    = 1'b0;
        if (pool_q != '0) begin
          pool_d = pool_q - 1'b1;
        end
        if (phase_q) begin
          res_d.new_block_opened = 1'b1;
          if (free_q == '0) begin
            res_d.status = fpbm_pkg::ST_NO_PAGES;
          end
        end else begin
          cur_d  = best_q;
          inst_d = 1'b1;
        end
      end
      fpbm_pkg::S_WIPE: begin
        wipe_d = wipe_q + 1'b1;
        mwe    = 1'b1;
        mwaddr = {blk_q, wipe_q};
        mwdata = '0;
      end
      fpbm_pkg::S_DONE: begin
        res_d.free_block_count = pool_q;
        ovalid_d               = 1'b1;
      end
      default: ;
    endcase
  end

  localparam int unsigned WpW_L = fpbm_pkg::WpW;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= fpbm_pkg::S_CLEAR;
      clr_q    <= '0;
      op_q     <= fpbm_pkg::OP_USER_ALLOC;
      phase_q  <= 1'b0;
      inst_q   <= 1'b0;
      scan_q   <= '0;
      found_q  <= 1'b0;
      wipe_q   <= '0;
      free_q   <= fpbm_pkg::TotalPages;
      pool_q   <= fpbm_pkg::PoolAtReset;
      nseq_q   <= fpbm_pkg::SeqAtReset;
      dwl_q    <= 1'b1;
      ovalid_q <= 1'b0;
      for (int i = 0; i < fpbm_pkg::Slots; i++) begin
        otbl_q[i] <= BW'(i);
      end
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      op_q     <= op_d;
      phase_q  <= phase_d;
      inst_q   <= inst_d;
      scan_q   <= scan_d;
      found_q  <= found_d;
      wipe_q   <= wipe_d;
      free_q   <= free_d;
      pool_q   <= pool_d;
      nseq_q   <= nseq_d;
      ovalid_q <= ovalid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        dwl_q <= cfg_data_i;
      end
      if (otbl_we) begin
        otbl_q[slot] <= best_q;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    stream_q <= stream_d;
    blk_q    <= blk_d;
    page_q   <= page_d;
    cur_q    <= cur_d;
    best_q   <= best_d;
    bent_q   <= bent_d;
    mn_q     <= mn_d;
    mx_q     <= mx_d;
    cold_q   <= cold_d;
    res_q    <= res_d;
  end

`ifndef SYNTHESIS
  // no item is taken during the clearing pass
  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fpbm_pkg::S_CLEAR) |-> !s_axis_tready)
    else $error("item accepted during clearing pass");

  // the pool never holds more than every block
  a_pool_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pool_q <= fpbm_pkg::CountW'(fpbm_pkg::Blocks))
    else $error("pool count above block count");

  // free pages never exceed the plane size
  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= fpbm_pkg::TotalPages)
    else $error("free pages above plane size");

  // an accepted item leaves idle and never shows a result at once
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != fpbm_pkg::S_IDLE) && !m_axis_tvalid)
    else $error("result shown without processing");
`endif

endmodule
`default_nettype wire
